// ===== sv/tws_pkg.sv =====
`timescale 1ns / 1ps
package tws_pkg;

	// default geometry
	localparam int TEX_SIZE_DEF     = 64;
	localparam int NUM_TEXTURES_DEF = 8;
	localparam int MAX_ROWS_DEF     = 1024;

	// texel store
	localparam int MEM_AW = 15;

	// screen height arithmetic width (covers MAX_ROWS up to 4096)
	localparam int HS_W = 13;

	// register reset values
	localparam logic [10:0] SCREEN_RST = 11'd800;
	localparam logic [31:0] CEIL_RST   = 32'hFF44_4444;
	localparam logic [31:0] FLOOR_RST  = 32'hFF88_8888;
	localparam logic [8:0]  DIM_RST    = 9'd179;
	localparam logic [8:0]  DIM_MAX    = 9'd256;

	// register map (word index)
	typedef enum logic [1:0] {
		REG_SCREEN = 2'd0,
		REG_CEIL   = 2'd1,
		REG_FLOOR  = 2'd2,
		REG_DIM    = 2'd3
	} cfg_reg_t;

	// result region codes
	typedef enum logic [1:0] {
		RGN_CEIL  = 2'd0,
		RGN_WALL  = 2'd1,
		RGN_FLOOR = 2'd2
	} region_t;

	// item kind codes
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_SHADE = 1'b1;

endpackage

// ===== sv/tws_if.sv =====
`timescale 1ns / 1ps
// input item channel
interface tws_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [14:0] texel_address;
	logic [31:0] texel_value;
	logic [9:0]  row;
	logic [23:0] wall_height;
	logic [15:0] hit_x;
	logic [15:0] hit_y;
	logic        hit_vertical;
	logic [3:0]  texture_number;

	modport source (output valid, kind, texel_address, texel_value, row, wall_height,
		hit_x, hit_y, hit_vertical, texture_number, input ready);
	modport sink (input valid, kind, texel_address, texel_value, row, wall_height,
		hit_x, hit_y, hit_vertical, texture_number, output ready);
endinterface

// result channel
interface tws_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_color;
	logic [1:0]  region;

	modport source (output valid, pixel_color, region, input ready);
	modport sink (input valid, pixel_color, region, output ready);
endinterface

// ===== sv/textured_wall_column_shader_core.sv =====
`timescale 1ns / 1ps
// Path of a beat: stages 1, 2, the divider bank, stages 4, 5 and the output register.
// Throughput: one beat per cycle while results are taken; the texel row divider is
// one pipeline stage per quotient bit and the texel memory does one access per cycle
// at a single stage. The whole pipeline holds while a finished result is not taken.
// Reset (arst_n, asynchronous, active low) clears valid bits and loads register
// defaults; the texel memory is not cleared and must be written before use.
module textured_wall_column_shader_core #(
	parameter int TEX_SIZE     = tws_pkg::TEX_SIZE_DEF,
	parameter int NUM_TEXTURES = tws_pkg::NUM_TEXTURES_DEF,
	parameter int MAX_ROWS     = tws_pkg::MAX_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tws_in_if.sink      item,
	tws_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int QW = $clog2(TEX_SIZE);
	localparam int RW = 25 + QW;
	localparam int AW = tws_pkg::MEM_AW;
	localparam int HW = tws_pkg::HS_W;

	typedef struct packed {
		logic           vld;
		logic           wr;
		logic [1:0]     region;
		logic [AW-1:0]  addr;
		logic [31:0]    wdata;
		logic [15:0]    wdist;
		logic [23:0]    h;
		logic [RW-1:0]  rem;
		logic           sat;
		logic [QW-1:0]  q;
		logic [3:0]     tid;
		logic [QW-1:0]  tc;
		logic           vert;
	} stage_t;

	// configuration registers
	logic [10:0] screen_q;
	logic [31:0] ceil_q, floor_q;
	logic [8:0]  dim_q;
	logic        cfg_wr;
	tws_pkg::cfg_reg_t cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_sel = tws_pkg::cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_q <= tws_pkg::SCREEN_RST;
			ceil_q   <= tws_pkg::CEIL_RST;
			floor_q  <= tws_pkg::FLOOR_RST;
			dim_q    <= tws_pkg::DIM_RST;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				tws_pkg::REG_SCREEN: screen_q <= pwdata[10:0];
				tws_pkg::REG_CEIL:   ceil_q   <= pwdata;
				tws_pkg::REG_FLOOR:  floor_q  <= pwdata;
				tws_pkg::REG_DIM:    dim_q    <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_sel)
			tws_pkg::REG_SCREEN: prdata = 32'(screen_q);
			tws_pkg::REG_CEIL:   prdata = ceil_q;
			tws_pkg::REG_FLOOR:  prdata = floor_q;
			tws_pkg::REG_DIM:    prdata = 32'(dim_q);
			default:             prdata = '0;
		endcase
	end

	// pipeline advance
	logic out_vld_q;
	logic en;
	assign en = !out_vld_q || result.ready;
	assign item.ready = en;

	// stage 1: span bounds, region, distance into the wall, texture column and index
	stage_t n1, p_s1;
	logic [HW-1:0] hs;
	logic [24:0]   mid, h25, d25;
	logic [15:0]   top, bot_raw, bottom, row16;
	logic [15:0]   hit;
	logic [3:0]    tid_raw;

	always_comb begin
		hs      = (HW'(screen_q) > HW'(MAX_ROWS)) ? HW'(MAX_ROWS) : HW'(screen_q);
		mid     = 25'(hs[HW-1:1]) << 9;
		h25     = 25'(item.wall_height);
		row16   = 16'(item.row);
		top     = (mid > h25) ? 16'((mid - h25) >> 9) : '0;
		bot_raw = 16'((mid + h25) >> 9);
		bottom  = (bot_raw > 16'(hs)) ? 16'(hs) : bot_raw;
		d25     = 25'({item.row, 9'b0}) + h25;
		hit     = item.hit_vertical ? item.hit_y : item.hit_x;
		tid_raw = item.texture_number - 4'd1;

		n1        = '0;
		n1.wr     = (item.kind == tws_pkg::KIND_WRITE);
		n1.vld    = item.valid && (n1.wr || (HW'(item.row) < hs));
		n1.addr   = item.texel_address;
		n1.wdata  = item.texel_value;
		n1.h      = item.wall_height;
		n1.wdist  = (d25 > mid) ? 16'((d25 - mid) >> 9) : '0;
		n1.tc     = QW'(hit % 16'(TEX_SIZE));
		n1.tid    = (5'(tid_raw) >= 5'(NUM_TEXTURES)) ? 4'(NUM_TEXTURES - 1) : tid_raw;
		n1.vert   = item.hit_vertical;
		if (row16 < top)
			n1.region = tws_pkg::RGN_CEIL;
		else if (row16 < bottom)
			n1.region = tws_pkg::RGN_WALL;
		else
			n1.region = tws_pkg::RGN_FLOOR;
	end

	// stage 2: dividend and saturation test
	stage_t n2, p_s2;
	always_comb begin
		n2     = p_s1;
		n2.rem = RW'(p_s1.wdist) * RW'(TEX_SIZE * 256);
		n2.sat = n2.rem >= (RW'(p_s1.h) << QW);
		n2.q   = '0;
	end

	// stage 3 bank: restoring division, one quotient bit per stage
	stage_t dv_in [QW];
	stage_t dv_nx [QW];
	stage_t dv_s3 [QW];

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		logic [RW-1:0] dsh;
		if (k == 0) begin : g_first
			assign dv_in[k] = p_s2;
		end else begin : g_next
			assign dv_in[k] = dv_s3[k-1];
		end
		always_comb begin
			dsh      = RW'(dv_in[k].h) << B;
			dv_nx[k] = dv_in[k];
			if (dv_in[k].rem >= dsh) begin
				dv_nx[k].rem  = dv_in[k].rem - dsh;
				dv_nx[k].q[B] = 1'b1;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_s3[k].vld <= 1'b0;
			else if (en)
				dv_s3[k] <= dv_nx[k];
		end
	end

	// stage 4: texel row clamp and read address
	stage_t n4, p_s4, dv_last;
	logic [QW-1:0] tr;
	assign dv_last = dv_s3[QW-1];
	always_comb begin
		tr = (dv_last.sat || (dv_last.q > QW'(TEX_SIZE - 1))) ? QW'(TEX_SIZE - 1) : dv_last.q;
		n4   = dv_last;
		n4.q = tr;
		if (!dv_last.wr)
			n4.addr = AW'((32'(dv_last.tid) * 32'(TEX_SIZE) + 32'(tr)) * 32'(TEX_SIZE)
				+ 32'(dv_last.tc));
	end

	// stage 5: texel memory access (writes and reads kept in item order)
	stage_t p_s5;
	logic [31:0] mem [2**AW];
	logic [31:0] rdata_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			if (p_s4.vld && p_s4.wr)
				mem[p_s4.addr] <= p_s4.wdata;
			rdata_s5 <= mem[p_s4.addr];
		end
	end

	// stage registers 1, 2, 4, 5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s1.vld <= 1'b0;
			p_s2.vld <= 1'b0;
			p_s4.vld <= 1'b0;
			p_s5.vld <= 1'b0;
		end else if (en) begin
			p_s1 <= n1;
			p_s2 <= n2;
			p_s4 <= n4;
			p_s5 <= p_s4;
		end
	end

	// output stage: vertical-hit dimming and color select
	logic [8:0]  f;
	logic [16:0] pr, pg, pb;
	logic [7:0]  cr, cg, cb;
	logic [31:0] color_nx;
	always_comb begin
		f  = (dim_q > tws_pkg::DIM_MAX) ? tws_pkg::DIM_MAX : dim_q;
		pr = 17'(rdata_s5[23:16]) * 17'(f);
		pg = 17'(rdata_s5[15:8]) * 17'(f);
		pb = 17'(rdata_s5[7:0]) * 17'(f);
		cr = (pr[16:8] > 9'd255) ? 8'hFF : pr[15:8];
		cg = (pg[16:8] > 9'd255) ? 8'hFF : pg[15:8];
		cb = (pb[16:8] > 9'd255) ? 8'hFF : pb[15:8];
		unique case (tws_pkg::region_t'(p_s5.region))
			tws_pkg::RGN_CEIL:  color_nx = ceil_q;
			tws_pkg::RGN_FLOOR: color_nx = floor_q;
			tws_pkg::RGN_WALL:
				color_nx = p_s5.vert ? {rdata_s5[31:24], cr, cg, cb} : rdata_s5;
			default:            color_nx = floor_q;
		endcase
	end

	logic [31:0] color_q;
	logic [1:0]  region_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= p_s5.vld && !p_s5.wr;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_q  <= color_nx;
			region_q <= p_s5.region;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.pixel_color = color_q;
	assign result.region      = region_q;

`ifndef ASSERT_OFF
	// a texel write never turns into a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(en && p_s5.vld && p_s5.wr) |=> !out_vld_q)
		else $error("texel write produced a result");

	// with an empty output register the input is always taken
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |-> item.ready)
		else $error("input stalled with empty output");

	// the clamped texel row stays inside the texture
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(p_s4.vld && !p_s4.wr) |-> (p_s4.q <= QW'(TEX_SIZE - 1)))
		else $error("texel row out of range");
`endif

endmodule
